### src/unconsumed_producer_predictor_top_defines.svh
// Assertion helpers for the file that checks this block.
`ifndef UNCONSUMED_PRODUCER_PREDICTOR_TOP_DEFINES_SVH
`define UNCONSUMED_PRODUCER_PREDICTOR_TOP_DEFINES_SVH

// checked outside reset only
`define UPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define UPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/upp_pkg.sv
`timescale 1ns / 1ps
package upp_pkg;

  localparam int TAG_W   = 8;
  localparam int PC_W    = 48;
  localparam int CONS_W  = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_PREDICT = 2'd0;
  localparam logic [1:0] OP_PRODUCE = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELIM_EN  = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PC_W-1:0]  pc;
    logic             wrong_path;
    logic             is_control_flow;
    logic             eliminate_mark;
    logic [2:0]       dest_count;
    logic [TAG_W-1:0] dest_tag_0;
    logic [TAG_W-1:0] dest_tag_1;
    logic [TAG_W-1:0] dest_tag_2;
    logic [TAG_W-1:0] dest_tag_3;
    logic [TAG_W-1:0] reg_tag;
  } upp_req_t;

  typedef struct packed {
    logic eliminate;
    logic mispredict;
    logic trained;
  } upp_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRED,
    ST_PROD,
    ST_SELF,
    ST_SIB_RD,
    ST_SIB_WR,
    ST_TRAIN,
    ST_FREE,
    ST_DONE
  } upp_state_t;

endpackage

### src/upp_if.sv
`timescale 1ns / 1ps
interface upp_req_if;
  logic              valid;
  logic              ready;
  upp_pkg::upp_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface upp_rsp_if;
  logic              valid;
  logic              ready;
  upp_pkg::upp_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/upp_ram.sv
`timescale 1ns / 1ps
module upp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/unconsumed_producer_predictor_top.sv
`timescale 1ns / 1ps
// Unconsumed-producer predictor.
// req channel (valid/ready): one op per request; opcode selects predict,
// produce, consume read or release. rsp channel: exactly one result per
// request; eliminate, mispredict or trained, the others zero.
// cfg port: cfg_we/cfg_index/cfg_data write count_threshold (0),
// ratio_threshold (1) and eliminate_enable (2); write only while idle.
// Steps: predict reads the PC table once; produce writes each destination
// slot in turn; consume and release read the register entry, then walk its
// siblings, and release may also train the PC table and clear the entry.
// All state sits in two single-port-write memories (register table and
// PC table) with registered reads; each live sibling entry costs a read
// state and a write-back state, so the sibling walk sets the rate. One op
// is in flight at a time; the next request is taken as soon as the result
// is latched, even while the result register still waits on rsp.ready.
// Reset: a clearing pass over max(PHYS_REGS, PRED_ENTRIES) addresses
// zeroes both memories; req.ready stays low meanwhile. Config registers
// return to 16, 90, 1. A stalled receiver holds the result register; a
// finished op then waits until that register frees up.
module unconsumed_producer_predictor_top #(
  parameter int PHYS_REGS    = 256,
  parameter int DEST_SLOTS   = 4,
  parameter int PRED_ENTRIES = 1024,
  parameter int PC_BITS      = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [upp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [upp_pkg::CFG_W-1:0]             cfg_data,
  upp_req_if.sink                               req,
  upp_rsp_if.source                             rsp
);

  `include "unconsumed_producer_predictor_top_defines.svh"

  localparam int AW    = $clog2(PHYS_REGS);
  localparam int PW    = $clog2(PRED_ENTRIES);
  localparam int SIG_W = (PC_BITS < upp_pkg::PC_W) ? PC_BITS : upp_pkg::PC_W;
  localparam int SLOT_W = upp_pkg::TAG_W + 1;
  localparam int SIB_W = DEST_SLOTS * SLOT_W;
  localparam int RW    = 1 + SIG_W + upp_pkg::CONS_W + 2 + SIB_W;
  localparam int PRW   = 1 + SIG_W + 2 * upp_pkg::CNT_W;
  localparam int MAXD  = (PHYS_REGS > PRED_ENTRIES) ? PHYS_REGS : PRED_ENTRIES;
  localparam int CLW   = $clog2(MAXD);
  localparam int KW    = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
  localparam logic [KW-1:0] KLAST = KW'(DEST_SLOTS - 1);
  localparam int TAG_W = upp_pkg::TAG_W;
  localparam int CNT_W = upp_pkg::CNT_W;
  localparam int CONS_W = upp_pkg::CONS_W;

  typedef logic [DEST_SLOTS-1:0][SLOT_W-1:0] sibs_t;

  function automatic logic tag_ok(input logic [TAG_W-1:0] t);
    return 32'(t) < PHYS_REGS;
  endfunction

  // config
  logic [CNT_W-1:0] count_th;
  logic [6:0]       ratio_th;
  logic             elim_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_th <= CNT_W'(16);
      ratio_th <= 7'd90;
      elim_en  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        upp_pkg::CFG_COUNT_TH: count_th <= cfg_data;
        upp_pkg::CFG_RATIO_TH: ratio_th <= cfg_data[6:0];
        upp_pkg::CFG_ELIM_EN:  elim_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // memories
  logic          r_we;
  logic [AW-1:0] r_waddr, r_raddr;
  logic [RW-1:0] r_wdata, r_rdata;
  logic          p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [PRW-1:0] p_wdata, p_rdata;

  upp_ram #(.DEPTH(PHYS_REGS), .WIDTH(RW)) u_reg_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  upp_ram #(.DEPTH(PRED_ENTRIES), .WIDTH(PRW)) u_pred_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  logic              rd_valid;
  logic [SIG_W-1:0]  rd_sig;
  logic [CONS_W-1:0] rd_cons;
  logic [1:0]        rd_flags;
  sibs_t             rd_sibs;
  assign {rd_valid, rd_sig, rd_cons, rd_flags, rd_sibs} = r_rdata;

  logic             pd_valid;
  logic [SIG_W-1:0] pd_tag;
  logic [CNT_W-1:0] pd_prod, pd_uncons;
  assign {pd_valid, pd_tag, pd_prod, pd_uncons} = p_rdata;

  // sequencer registers
  upp_pkg::upp_state_t state, state_next;
  logic [CLW-1:0]    clr;
  logic [KW-1:0]     k;
  logic [1:0]        op_q;
  logic [SIG_W-1:0]  sig_q;
  logic              off_q, cf_q;
  logic [1:0]        flags_q;
  logic [TAG_W-1:0]  tag_q;
  sibs_t             sibs_q;
  logic [CONS_W-1:0] cons_q;
  logic              res_q;
  logic              rsp_valid;
  upp_pkg::upp_rsp_t rsp_data;

  logic [3:0][TAG_W-1:0] dtags;
  logic [2:0]            ncap;
  sibs_t                 prod_list, self_clean, rd_clean;
  logic                  accept, sib_done, sib_live, none_left, rsp_free;
  logic                  pred_hit;
  logic [22:0]           lhs, rhs;
  logic                  train_hit;
  logic [CNT_W-1:0]      pr_new, un_new;
  logic [CONS_W-1:0]     cons_inc;
  upp_pkg::upp_state_t   end_state;

  assign dtags = {req.data.dest_tag_3, req.data.dest_tag_2,
                  req.data.dest_tag_1, req.data.dest_tag_0};
  assign ncap = (32'(req.data.dest_count) > DEST_SLOTS) ? 3'(DEST_SLOTS)
                                                         : req.data.dest_count;

  always_comb begin
    for (int s = 0; s < DEST_SLOTS; s++) begin
      prod_list[s] = (3'(s) < ncap && tag_ok(dtags[s])) ? {1'b1, dtags[s]}
                                                        : SLOT_W'(0);
      self_clean[s] = (rd_sibs[s][TAG_W] && rd_sibs[s][TAG_W-1:0] == tag_q)
                      ? SLOT_W'(0) : rd_sibs[s];
      rd_clean[s] = self_clean[s];
    end
  end

  always_comb begin
    none_left = 1'b1;
    for (int s = 0; s < DEST_SLOTS; s++) begin
      if (sibs_q[s][TAG_W]) none_left = 1'b0;
    end
  end

  assign accept   = req.valid && req.ready;
  assign sib_done = (k == KLAST);
  assign sib_live = sibs_q[k][TAG_W] && tag_ok(sibs_q[k][TAG_W-1:0]);
  assign rsp_free = !rsp_valid || rsp.ready;

  // predict compare: u*100 >= ratio*p
  assign lhs = 23'(pd_uncons) * 23'd100;
  assign rhs = 23'(ratio_th) * 23'(pd_prod);
  assign pred_hit = !cf_q && pd_valid && pd_tag == sig_q &&
                    pd_uncons >= count_th && lhs >= rhs;

  assign train_hit = pd_valid && pd_tag == sig_q;
  always_comb begin
    pr_new = train_hit ? pd_prod : CNT_W'(0);
    un_new = train_hit ? pd_uncons : CNT_W'(0);
    if (pr_new != {CNT_W{1'b1}}) pr_new = pr_new + CNT_W'(1);
    if (cons_q == CONS_W'(0) && un_new != {CNT_W{1'b1}}) un_new = un_new + CNT_W'(1);
  end

  assign cons_inc = (rd_cons == {CONS_W{1'b1}}) ? rd_cons : rd_cons + CONS_W'(1);

  always_comb begin
    if (op_q == upp_pkg::OP_CONSUME) begin
      end_state = upp_pkg::ST_DONE;
    end else if (none_left && !flags_q[0]) begin
      end_state = upp_pkg::ST_TRAIN;
    end else begin
      end_state = upp_pkg::ST_FREE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      upp_pkg::ST_CLEAR: if (32'(clr) == MAXD - 1) state_next = upp_pkg::ST_IDLE;
      upp_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.data.opcode)
            upp_pkg::OP_PREDICT: state_next = upp_pkg::ST_PRED;
            upp_pkg::OP_PRODUCE: state_next = upp_pkg::ST_PROD;
            default: state_next = tag_ok(req.data.reg_tag) ? upp_pkg::ST_SELF
                                                           : upp_pkg::ST_DONE;
          endcase
        end
      end
      upp_pkg::ST_PRED: state_next = upp_pkg::ST_DONE;
      upp_pkg::ST_PROD: if (sib_done) state_next = upp_pkg::ST_DONE;
      upp_pkg::ST_SELF: begin
        if (!rd_valid || (op_q == upp_pkg::OP_CONSUME && off_q)) begin
          state_next = upp_pkg::ST_DONE;
        end else begin
          state_next = upp_pkg::ST_SIB_RD;
        end
      end
      upp_pkg::ST_SIB_RD: begin
        if (sib_live) state_next = upp_pkg::ST_SIB_WR;
        else if (sib_done) state_next = end_state;
      end
      upp_pkg::ST_SIB_WR: state_next = sib_done ? end_state : upp_pkg::ST_SIB_RD;
      upp_pkg::ST_TRAIN: state_next = upp_pkg::ST_FREE;
      upp_pkg::ST_FREE: state_next = upp_pkg::ST_DONE;
      upp_pkg::ST_DONE: if (rsp_free) state_next = upp_pkg::ST_IDLE;
      default: state_next = upp_pkg::ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    r_we    = 1'b0;
    r_waddr = AW'(sibs_q[k][TAG_W-1:0]);
    r_wdata = '0;
    p_we    = 1'b0;
    p_waddr = sig_q[PW-1:0];
    p_wdata = {1'b1, sig_q, pr_new, un_new};
    r_raddr = (state == upp_pkg::ST_IDLE) ? AW'(req.data.reg_tag)
                                          : AW'(sibs_q[k][TAG_W-1:0]);
    p_raddr = (state == upp_pkg::ST_IDLE) ? req.data.pc[PW-1:0] : sig_q[PW-1:0];
    case (state)
      upp_pkg::ST_CLEAR: begin
        r_we    = 32'(clr) < PHYS_REGS;
        r_waddr = AW'(clr);
        p_we    = 32'(clr) < PRED_ENTRIES;
        p_waddr = PW'(clr);
        p_wdata = '0;
      end
      upp_pkg::ST_PROD: begin
        r_we    = sibs_q[k][TAG_W];
        r_wdata = {1'b1, sig_q, CONS_W'(0), flags_q, sibs_q};
      end
      upp_pkg::ST_SIB_WR: begin
        r_we = rd_valid;
        if (op_q == upp_pkg::OP_CONSUME) begin
          r_wdata = {1'b1, rd_sig, cons_inc, rd_flags, rd_sibs};
        end else begin
          r_wdata = {1'b1, rd_sig, rd_cons, rd_flags, rd_clean};
        end
      end
      upp_pkg::ST_TRAIN: p_we = 1'b1;
      upp_pkg::ST_FREE: begin
        r_we    = 1'b1;
        r_waddr = AW'(tag_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upp_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == upp_pkg::ST_CLEAR) clr <= clr + CLW'(1);
    end
  end

  // op datapath
  always_ff @(posedge clk) begin
    case (state)
      upp_pkg::ST_IDLE: begin
        op_q    <= req.data.opcode;
        sig_q   <= SIG_W'(req.data.pc);
        off_q   <= req.data.wrong_path;
        cf_q    <= req.data.is_control_flow;
        flags_q <= {req.data.eliminate_mark, req.data.wrong_path};
        tag_q   <= req.data.reg_tag;
        sibs_q  <= prod_list;
        k       <= '0;
        res_q   <= 1'b0;
      end
      upp_pkg::ST_PRED: res_q <= pred_hit;
      upp_pkg::ST_PROD: k <= k + KW'(1);
      upp_pkg::ST_SELF: begin
        k <= '0;
        if (op_q == upp_pkg::OP_CONSUME) begin
          res_q  <= rd_valid && elim_en && rd_flags[1];
          sibs_q <= rd_sibs;
        end else begin
          sibs_q  <= self_clean;
          sig_q   <= rd_sig;
          cons_q  <= rd_cons;
          flags_q <= rd_flags;
        end
      end
      upp_pkg::ST_SIB_RD: if (!sib_live) k <= k + KW'(1);
      upp_pkg::ST_SIB_WR: k <= k + KW'(1);
      upp_pkg::ST_TRAIN: res_q <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == upp_pkg::ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == upp_pkg::ST_DONE && rsp_free) begin
      rsp_data.eliminate  <= res_q && op_q == upp_pkg::OP_PREDICT;
      rsp_data.mispredict <= res_q && op_q == upp_pkg::OP_CONSUME;
      rsp_data.trained    <= res_q && op_q == upp_pkg::OP_RELEASE;
    end
  end

  assign req.ready = (state == upp_pkg::ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  `UPP_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready, "request taken while busy")
  `UPP_ASSERT(a_no_rsp_in_clear, state == upp_pkg::ST_CLEAR |-> !rsp.valid, "result during clear")
  `UPP_ASSERT(a_one_field, rsp.valid |-> $onehot0({rsp.data.eliminate, rsp.data.mispredict, rsp.data.trained}), "several result bits")
  `UPP_ASSERT_ALWAYS(a_train_release, rst || state != upp_pkg::ST_TRAIN || op_q == upp_pkg::OP_RELEASE, "training outside release")

endmodule
